// ===== hw/rtl/fmr_pkg.sv =====
// Package for the frame rate meter: payload structs, state encoding, constants.
// No dependencies; used by frame_rate_meter_core.
`timescale 1ns / 1ps

package fmr_pkg;

  // Default sizes of the saturating counters
  localparam int ACC_BITS_DEF   = 48;
  localparam int COUNT_BITS_DEF = 20;

  // Field widths
  localparam int SEC_W    = 32;
  localparam int USEC_W   = 20;
  localparam int WIN_W    = 24;
  localparam int RATE_W   = 10;
  localparam int DIGIT_W  = 4;
  // seconds * 1e6 + micros fits in 52 bits
  localparam int TIME_W   = SEC_W + USEC_W;
  localparam int STEP_W   = 5;

  localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [RATE_W-1:0] RATE_MAX     = 10'd999;
  localparam logic [RATE_W-1:0] RATE_HUNDRED = 10'd100;
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 24'd500000;

  typedef struct packed {
    logic [SEC_W-1:0]  time_seconds;
    logic [USEC_W-1:0] time_micros;
  } in_t;

  typedef struct packed {
    logic [RATE_W-1:0]  rate_value;
    logic [DIGIT_W-1:0] hundreds_digit;
    logic [DIGIT_W-1:0] tens_digit;
    logic [DIGIT_W-1:0] ones_digit;
    logic               three_digits;
    logic               rate_updated;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_DELTA,
    ST_ACC,
    ST_MUL_C,
    ST_CHK,
    ST_DIV,
    ST_DABBLE,
    ST_FIN
  } state_e;

endpackage

// ===== hw/rtl/frame_rate_meter_core.sv =====
// Frame rate meter top level: bit-serial timestamp conversion, division and BCD.
// Depends on fmr_pkg.
`timescale 1ns / 1ps

// Usage:
// Each transfer on the input channel (in_valid_i / in_stall_o) is one frame
// event carrying its timestamp. Exactly one result per frame leaves on the
// output channel (out_valid_o / out_stall_i): the current rate, its decimal
// digits, and a flag set when this frame closed a measurement window.
// The window length is written through cfg_valid_i / cfg_data_i; the user
// writes it while the block is idle, which the block itself does not enforce. cfg_ready_o is always high.
// Processing: the seconds field is converted to microseconds one bit per cycle.
// A frame that closes a window then multiplies the frame count by 1e6
// bit-serially, makes one range check, runs a restoring division and
// shifts the rate to BCD; a rate that overflows skips the division.
// One frame is in work at a time.
// The finished result sits in an output register; the next frame is taken
// while it waits. If the receiver stalls, the result holds and a following
// frame waits in its last cycle until the output register frees.
// Reset: rate 0, no previous timestamp, window 500000 us.
module frame_rate_meter_core #(
  parameter int ACC_BITS   = fmr_pkg::ACC_BITS_DEF,
  parameter int COUNT_BITS = fmr_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  fmr_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output fmr_pkg::out_t             out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [fmr_pkg::WIN_W-1:0] cfg_data_i
);

  localparam int TIME_W = fmr_pkg::TIME_W;
  localparam int SUM_W  = ((ACC_BITS > TIME_W) ? ACC_BITS : TIME_W) + 1;
  localparam int NUM_W  = COUNT_BITS + fmr_pkg::USEC_W;
  localparam int DIV_W  = ACC_BITS + fmr_pkg::RATE_W;
  localparam int CMP_W  = ((NUM_W > DIV_W) ? NUM_W : DIV_W) + 1;
  localparam logic [ACC_BITS-1:0]   AccMax   = {ACC_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  fmr_pkg::state_e state_q, state_d;
  logic [fmr_pkg::STEP_W-1:0]  step_q, step_d;
  logic [fmr_pkg::SEC_W-1:0]   sec_q, sec_d;
  logic [fmr_pkg::USEC_W-1:0]  usec_q, usec_d;
  logic                        sec_nz_q, sec_nz_d;
  logic [TIME_W-1:0]           now_q, now_d;
  logic [TIME_W-1:0]           then_q, then_d;
  logic                        have_last_q, have_last_d;
  logic [TIME_W-1:0]           delta_q, delta_d;
  logic [ACC_BITS-1:0]         acc_q, acc_d;
  logic [COUNT_BITS-1:0]       frames_q, frames_d;
  logic [NUM_W-1:0]            num_q, num_d;
  logic [DIV_W-1:0]            div_q, div_d;
  logic [fmr_pkg::RATE_W-1:0]  quo_q, quo_d;
  logic [fmr_pkg::RATE_W-1:0]  rate_q, rate_d;
  logic [3*fmr_pkg::DIGIT_W-1:0] bcd_q, bcd_d;
  logic                        updated_q, updated_d;
  logic [fmr_pkg::WIN_W-1:0]   window_q, window_d;
  logic                        out_valid_q, out_valid_d;
  fmr_pkg::out_t               out_q, out_d;

  // Datapath helpers
  logic [TIME_W-1:0]         now_step;
  logic [SUM_W-1:0]          acc_sum;
  logic [ACC_BITS-1:0]       acc_new;
  logic [fmr_pkg::WIN_W-1:0] win_eff;
  logic [NUM_W-1:0]          num_step;
  logic                      div_ge;
  logic                      rate_ovf;
  logic [3*fmr_pkg::DIGIT_W-1:0] bcd_adj;
  logic                      out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != fmr_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Shift-add of one seconds bit times 1e6; micros joins on the last bit
  always_comb begin
    now_step = {now_q[TIME_W-2:0], 1'b0};
    if (sec_q[fmr_pkg::SEC_W-1]) begin
      now_step = now_step + TIME_W'(fmr_pkg::USEC_PER_SEC);
    end
    if (step_q == '0) begin
      now_step = now_step + TIME_W'(usec_q);
    end
  end

  // Saturating accumulate and window check
  always_comb begin
    acc_sum = SUM_W'(acc_q) + SUM_W'(delta_q);
    acc_new = (acc_sum > SUM_W'(AccMax)) ? AccMax : acc_sum[ACC_BITS-1:0];
    win_eff = (window_q == '0) ? fmr_pkg::WIN_W'(1) : window_q;
  end

  // Shift-add of one frame count bit times 1e6
  always_comb begin
    num_step = {num_q[NUM_W-2:0], 1'b0};
    if (frames_q[COUNT_BITS-1]) begin
      num_step = num_step + NUM_W'(fmr_pkg::USEC_PER_SEC);
    end
  end

  // Division compares
  assign div_ge   = CMP_W'(num_q) >= CMP_W'(div_q);
  assign rate_ovf = CMP_W'(num_q) >= CMP_W'({div_q, 1'b0});

  // Double dabble: add 3 to each digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
                                                    : bcd_q[i*4 +: 4];
    end
  end

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    sec_d       = sec_q;
    usec_d      = usec_q;
    sec_nz_d    = sec_nz_q;
    now_d       = now_q;
    then_d      = then_q;
    have_last_d = have_last_q;
    delta_d     = delta_q;
    acc_d       = acc_q;
    frames_d    = frames_q;
    num_d       = num_q;
    div_d       = div_q;
    quo_d       = quo_q;
    rate_d      = rate_q;
    bcd_d       = bcd_q;
    updated_d   = updated_q;
    window_d    = window_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (cfg_valid_i) begin
      window_d = cfg_data_i;
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      fmr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          sec_d     = in_data_i.time_seconds;
          usec_d    = in_data_i.time_micros;
          sec_nz_d  = (in_data_i.time_seconds != '0);
          now_d     = '0;
          updated_d = 1'b0;
          step_d    = fmr_pkg::STEP_W'(fmr_pkg::SEC_W - 1);
          state_d   = fmr_pkg::ST_MUL_T;
        end
      end

      fmr_pkg::ST_MUL_T: begin
        now_d = now_step;
        sec_d = {sec_q[fmr_pkg::SEC_W-2:0], 1'b0};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = fmr_pkg::ST_DELTA;
        end
      end

      // Elapsed time, clamped at zero; store this timestamp
      fmr_pkg::ST_DELTA: begin
        delta_d     = (now_q > then_q) ? now_q - then_q : '0;
        then_d      = now_q;
        have_last_d = sec_nz_q;
        state_d     = have_last_q ? fmr_pkg::ST_ACC : fmr_pkg::ST_FIN;
      end

      fmr_pkg::ST_ACC: begin
        if (frames_q != CountMax) begin
          frames_d = frames_q + 1'b1;
        end
        if (acc_new >= ACC_BITS'(win_eff)) begin
          // Window closed: divisor starts at acc << 9, accumulator clears
          div_d     = DIV_W'({acc_new, 9'd0});
          acc_d     = '0;
          num_d     = '0;
          updated_d = 1'b1;
          step_d    = fmr_pkg::STEP_W'(COUNT_BITS - 1);
          state_d   = fmr_pkg::ST_MUL_C;
        end else begin
          acc_d   = acc_new;
          state_d = fmr_pkg::ST_FIN;
        end
      end

      // frames * 1e6; the count shifts out and ends cleared
      fmr_pkg::ST_MUL_C: begin
        num_d    = num_step;
        frames_d = {frames_q[COUNT_BITS-2:0], 1'b0};
        step_d   = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = fmr_pkg::ST_CHK;
        end
      end

      // Quotient of 1024 or more saturates without dividing
      fmr_pkg::ST_CHK: begin
        if (rate_ovf) begin
          quo_d   = fmr_pkg::RATE_MAX;
          rate_d  = fmr_pkg::RATE_MAX;
          bcd_d   = '0;
          step_d  = fmr_pkg::STEP_W'(fmr_pkg::RATE_W - 1);
          state_d = fmr_pkg::ST_DABBLE;
        end else begin
          quo_d   = '0;
          step_d  = fmr_pkg::STEP_W'(fmr_pkg::RATE_W - 1);
          state_d = fmr_pkg::ST_DIV;
        end
      end

      // Restoring division, one quotient bit per cycle
      fmr_pkg::ST_DIV: begin
        if (div_ge) begin
          num_d = num_q - NUM_W'(div_q);
        end
        quo_d  = {quo_q[fmr_pkg::RATE_W-2:0], div_ge};
        div_d  = div_q >> 1;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          if ({quo_q[fmr_pkg::RATE_W-2:0], div_ge} > fmr_pkg::RATE_MAX) begin
            quo_d = fmr_pkg::RATE_MAX;
          end
          rate_d  = quo_d;
          bcd_d   = '0;
          step_d  = fmr_pkg::STEP_W'(fmr_pkg::RATE_W - 1);
          state_d = fmr_pkg::ST_DABBLE;
        end
      end

      // Binary to BCD, one rate bit per cycle
      fmr_pkg::ST_DABBLE: begin
        bcd_d  = {bcd_adj[3*fmr_pkg::DIGIT_W-2:0], quo_q[fmr_pkg::RATE_W-1]};
        quo_d  = {quo_q[fmr_pkg::RATE_W-2:0], 1'b0};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = fmr_pkg::ST_FIN;
        end
      end

      // Load the output register once it is free
      fmr_pkg::ST_FIN: begin
        if (out_free) begin
          out_d.rate_value     = rate_q;
          out_d.hundreds_digit = bcd_q[11:8];
          out_d.tens_digit     = bcd_q[7:4];
          out_d.ones_digit     = bcd_q[3:0];
          out_d.three_digits   = (rate_q >= fmr_pkg::RATE_HUNDRED);
          out_d.rate_updated   = updated_q;
          out_valid_d          = 1'b1;
          state_d              = fmr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = fmr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and meter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fmr_pkg::ST_IDLE;
      step_q      <= '0;
      then_q      <= '0;
      have_last_q <= 1'b0;
      acc_q       <= '0;
      frames_q    <= '0;
      rate_q      <= '0;
      bcd_q       <= '0;
      updated_q   <= 1'b0;
      window_q    <= fmr_pkg::WINDOW_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      then_q      <= then_d;
      have_last_q <= have_last_d;
      acc_q       <= acc_d;
      frames_q    <= frames_d;
      rate_q      <= rate_d;
      bcd_q       <= bcd_d;
      updated_q   <= updated_d;
      window_q    <= window_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers of the serial datapath
  always_ff @(posedge clk_i) begin
    sec_q    <= sec_d;
    usec_q   <= usec_d;
    sec_nz_q <= sec_nz_d;
    now_q    <= now_d;
    delta_q  <= delta_d;
    num_q    <= num_d;
    div_q    <= div_d;
    quo_q    <= quo_d;
    out_q    <= out_d;
  end

endmodule
